### src/kfph_pkg.sv
// ----------------------------------------------------------------------------
// kfph_pkg: shared types and constants for the PIN hash block
// Lane and state types, round bounds, the round constant table and the
// rho rotation amounts of Keccak-f[200].
// ----------------------------------------------------------------------------
package kfph_pkg;

    // One 8-bit lane and the full 25-lane state, lane (x,y) at index x + 5*y.
    typedef logic [7:0]       lane_t;
    typedef lane_t [24:0]     state_t;

    // Round bookkeeping. ROUNDS may be lowered; the last rounds are kept.
    localparam int unsigned TOTAL_ROUNDS = 18;
    localparam int unsigned ROUNDS       = 18;
    localparam int unsigned RND_W        = 5;
    localparam logic [RND_W-1:0] ROUND_FIRST = RND_W'(TOTAL_ROUNDS - ROUNDS);
    localparam logic [RND_W-1:0] ROUND_LAST  = RND_W'(TOTAL_ROUNDS - 1);

    // Padding block 01 00 00 80, byte 0 in the low bits.
    localparam logic [31:0] PAD_BLOCK = 32'h8000_0001;

    // Rho offsets reduced mod 8 for 8-bit lanes, indexed x + 5*y.
    localparam logic [2:0] ROT_OFF [25] = '{
        3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
        3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
        3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
        3'd2, 3'd2, 3'd5, 3'd0, 3'd6
    };

    // Low byte of the standard Keccak round constants.
    function automatic lane_t rc_of(input logic [RND_W-1:0] idx);
        lane_t rc;
        unique case (idx)
            5'd0:    rc = 8'h01;
            5'd1:    rc = 8'h82;
            5'd2:    rc = 8'h8a;
            5'd3:    rc = 8'h00;
            5'd4:    rc = 8'h8b;
            5'd5:    rc = 8'h01;
            5'd6:    rc = 8'h81;
            5'd7:    rc = 8'h09;
            5'd8:    rc = 8'h8a;
            5'd9:    rc = 8'h88;
            5'd10:   rc = 8'h09;
            5'd11:   rc = 8'h0a;
            5'd12:   rc = 8'h8b;
            5'd13:   rc = 8'h8b;
            5'd14:   rc = 8'h89;
            5'd15:   rc = 8'h03;
            5'd16:   rc = 8'h02;
            5'd17:   rc = 8'h80;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage

### src/kfph_round.sv
// ----------------------------------------------------------------------------
// kfph_round: one round of Keccak-f[200]
// Combinational theta, rho, pi, chi and iota over the 25-lane state. The
// sequencer in the top level feeds its output back for every round.
// ----------------------------------------------------------------------------
module kfph_round
    import kfph_pkg::*;
(
    input  state_t state_in,
    input  lane_t  rc,
    output state_t state_out
);

    lane_t  col_par [5];
    lane_t  col_mix [5];
    state_t a_st;
    state_t b_st;
    state_t chi_st;

    // Theta: column parities and the mixing term for each column.
    for (genvar x = 0; x < 5; x++)
    begin : g_col
        assign col_par[x] = state_in[x] ^ state_in[x+5] ^ state_in[x+10]
                          ^ state_in[x+15] ^ state_in[x+20];
    end

    for (genvar x = 0; x < 5; x++)
    begin : g_mix
        assign col_mix[x] = col_par[(x+4)%5]
                          ^ {col_par[(x+1)%5][6:0], col_par[(x+1)%5][7]};
    end

    // Theta applied, then rho rotation and pi lane move.
    for (genvar y = 0; y < 5; y++)
    begin : g_rp_y
        for (genvar x = 0; x < 5; x++)
        begin : g_rp_x
            logic [15:0] dbl;
            assign a_st[x+5*y] = state_in[x+5*y] ^ col_mix[x];
            assign dbl = {a_st[x+5*y], a_st[x+5*y]} << ROT_OFF[x+5*y];
            assign b_st[y+5*((2*x+3*y)%5)] = dbl[15:8];
        end
    end

    // Chi along each row.
    for (genvar y = 0; y < 5; y++)
    begin : g_chi_y
        for (genvar x = 0; x < 5; x++)
        begin : g_chi_x
            assign chi_st[x+5*y] = b_st[x+5*y]
                                 ^ (~b_st[(x+1)%5+5*y] & b_st[(x+2)%5+5*y]);
        end
    end

    // Iota on lane zero.
    always_comb
    begin
        state_out    = chi_st;
        state_out[0] = chi_st[0] ^ rc;
    end

endmodule

### src/keccak_f200_pin_hash_top.sv
// ----------------------------------------------------------------------------
// keccak_f200_pin_hash_top: 64-bit Keccak-f[200] sponge digest of a PIN
// An iterative sponge: a single round unit runs three permutations in turn.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one 32-bit PIN word per handshake; the master
//   stream returns one 64-bit digest word for each PIN word taken.
//   After a word is accepted the state is loaded with the PIN in lanes 0..3
//   and the shared round unit runs one round per cycle, except while a round
//   is held for the output register (below): 18 rounds absorb the PIN, 18
//   more after the pad block is XORed in, 18 more after the first four
//   digest bytes are squeezed. The digest becomes valid when the last
//   squeeze round completes, and s_tready returns at the same time.
//   s_tready stays low while a hash is in progress. The digest waits in an
//   output register; a new PIN word may be taken while it waits. The first
//   four digest bytes of the next hash land in that register, so if the
//   receiver still holds back the previous digest when the next hash
//   reaches the last round of its pad permutation, the sequencer holds that
//   round until the output register frees up.
//   Reset (rst_n low) drops the digest valid flag and returns to idle; any
//   hash in progress is dropped.
// ----------------------------------------------------------------------------
module keccak_f200_pin_hash_top
    import kfph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pin_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] digest
);

    // Sequencer states and sponge phases.
    localparam logic       ST_IDLE   = 1'b0;
    localparam logic       ST_RUN    = 1'b1;
    localparam logic [1:0] PH_ABSORB = 2'd0;
    localparam logic [1:0] PH_PAD    = 2'd1;
    localparam logic [1:0] PH_SQZ    = 2'd2;

    logic             state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    state_t           st_reg, st_next;
    logic [63:0]      dig_reg, dig_next;
    logic             m_tvalid_reg, m_tvalid_next;

    state_t           round_out;
    logic             last_rnd;
    logic             out_busy;
    logic             advance;
    logic             s_fire;

    // Shared round unit.
    kfph_round u_round (
        .state_in  (st_reg),
        .rc        (rc_of(rnd_reg)),
        .state_out (round_out)
    );

    // Both squeeze points write the output register, so each waits for it.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dig_reg;
    assign last_rnd = (rnd_reg == ROUND_LAST);
    assign out_busy = m_tvalid_reg && !m_tready;
    assign advance  = (state_reg == ST_RUN)
                   && !(last_rnd && (phase_reg != PH_ABSORB) && out_busy);

    // Sequencer and sponge datapath.
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        rnd_next      = rnd_reg;
        st_next       = st_reg;
        dig_next      = dig_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    st_next      = '0;
                    st_next[3:0] = s_tdata;
                    phase_next   = PH_ABSORB;
                    rnd_next     = ROUND_FIRST;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    st_next  = round_out;
                    rnd_next = last_rnd ? ROUND_FIRST : rnd_reg + 1'b1;
                    if (last_rnd)
                    begin
                        case (phase_reg)
                            PH_ABSORB:
                            begin
                                st_next[3:0] = round_out[3:0] ^ PAD_BLOCK;
                                phase_next   = PH_PAD;
                            end
                            PH_PAD:
                            begin
                                dig_next[31:0] = round_out[3:0];
                                phase_next     = PH_SQZ;
                            end
                            default:
                            begin
                                dig_next[63:32] = round_out[3:0];
                                m_tvalid_next   = 1'b1;
                                phase_next      = PH_ABSORB;
                                state_next      = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_ABSORB;
            rnd_reg      <= ROUND_FIRST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            rnd_reg      <= rnd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Lane state and digest registers.
    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        dig_reg <= dig_next;
    end

`ifndef SYNTHESIS
    // An accepted word always starts a permutation at the first round.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (state_reg == ST_RUN) && (rnd_reg == ROUND_FIRST)
                   && (phase_reg == PH_ABSORB))
        else $error("hash did not start at the first absorb round");

    // A fresh digest only appears right after the last squeeze round.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |->
            ($past(state_reg) == ST_RUN) && ($past(phase_reg) == PH_SQZ)
            && $past(last_rnd))
        else $error("digest valid without a finished squeeze");

    // The round counter stays inside the selected round window.
    a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rnd_reg >= ROUND_FIRST) && (rnd_reg <= ROUND_LAST))
        else $error("round index out of range");

    // A waiting digest is never overwritten before it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> $stable(dig_reg))
        else $error("pending digest overwritten");

    // The sponge phase never reaches the unused code.
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("illegal sponge phase");
`endif

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Keccak-f[200] PIN hash block
// PIN words go in on the slave stream in random bursts, and the receiver
// stalls on a pattern of its own. Each accepted PIN is hashed by a local
// sponge model. Every digest word that comes back is compared in order
// with the oldest predicted digest.
// ----------------------------------------------------------------------------
module tb_top;
    import kfph_pkg::*;

    // Overall cycle budget. Each item is charged for the round cycles, the
    // longest sender gap and the longest receiver stall, with a wide margin.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_PINS  = 750;
    localparam int unsigned DRAIN_CYCLES = 60;

    // Full rho offsets, indexed x + 5*y. They are reduced mod 8 when applied.
    localparam int RHO_OFS [25] = '{
         0,  1, 62, 28, 27,
        36, 44,  6, 55, 20,
         3, 10, 43, 25, 39,
        41, 45, 15, 21,  8,
        18,  2, 61, 56, 14
    };

    // Low byte of the standard Keccak iota constants.
    localparam lane_t IOTA_RC [18] = '{
        8'h01, 8'h82, 8'h8a, 8'h00, 8'h8b, 8'h01, 8'h81, 8'h09, 8'h8a,
        8'h88, 8'h09, 8'h0a, 8'h8b, 8'h8b, 8'h89, 8'h03, 8'h02, 8'h80
    };

    // Receiver behavior, chosen afresh for each stretch of cycles.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SELDOM,
        RX_HOLD
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] pin_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;    // [63:0] digest

    logic [63:0] pending_digests [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    bit          sender_idles   = 1'b1;
    rx_mode_t    rx_mode        = RX_ALWAYS;
    int unsigned rx_left        = 0;

    keccak_f200_pin_hash_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // Left rotation of one lane; the doubled lane makes a zero shift harmless.
    function automatic lane_t lane_rotl(input lane_t v, input int n);
        logic [15:0] twin;
        twin = {v, v} >> (8 - (n % 8));
        return twin[7:0];
    endfunction

    // One Keccak-f[200] round with iota constant number ridx.
    function automatic state_t f200_round(input state_t st, input int ridx);
        lane_t  col [5];
        lane_t  mix [5];
        state_t b;
        int     x;
        int     y;
        for (x = 0; x < 5; x++)
            col[x] = st[x] ^ st[x + 5] ^ st[x + 10] ^ st[x + 15] ^ st[x + 20];
        for (x = 0; x < 5; x++)
            mix[x] = col[(x + 4) % 5] ^ lane_rotl(col[(x + 1) % 5], 1);
        for (y = 0; y < 5; y++)
            for (x = 0; x < 5; x++)
                st[x + 5 * y] ^= mix[x];
        // Rho and pi together: lane (x,y) moves to (y, 2x+3y).
        for (y = 0; y < 5; y++)
            for (x = 0; x < 5; x++)
                b[y + 5 * ((2 * x + 3 * y) % 5)] =
                    lane_rotl(st[x + 5 * y], RHO_OFS[x + 5 * y]);
        for (y = 0; y < 5; y++)
            for (x = 0; x < 5; x++)
                st[x + 5 * y] = b[x + 5 * y] ^
                    (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
        st[0] ^= IOTA_RC[ridx];
        return st;
    endfunction

    // Reduced-round variants keep the last rounds of the full schedule.
    function automatic state_t f200_permute(input state_t st);
        int r;
        for (r = 0; r < int'(ROUNDS); r++)
            st = f200_round(st, int'(TOTAL_ROUNDS) - int'(ROUNDS) + r);
        return st;
    endfunction

    // Sponge: absorb the PIN, absorb the pad, squeeze two half digests.
    function automatic logic [63:0] pin_digest(input logic [31:0] pin);
        state_t      st;
        logic [63:0] dig;
        int          k;
        st = '0;
        for (k = 0; k < 4; k++)
            st[k] = pin[8 * k +: 8];
        st = f200_permute(st);
        st[0] ^= 8'h01;
        st[3] ^= 8'h80;
        st = f200_permute(st);
        for (k = 0; k < 4; k++)
            dig[8 * k +: 8] = st[k];
        st = f200_permute(st);
        for (k = 0; k < 4; k++)
            dig[8 * (k + 4) +: 8] = st[k];
        return dig;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Gaps between bursts of words on the slave side.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if (sender_idles && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 60);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Offer one PIN word and hold it until the block takes it.
    task automatic send_pin(input logic [31:0] pin);
        s_tvalid <= 1'b1;
        s_tdata  <= pin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_digests.push_back(pin_digest(pin));
        pace_sender();
    endtask

    // Extreme and structured PINs, including the pad block itself.
    task automatic test_edge_pins();
        logic [31:0] edge_pins [] = '{
            32'h0000_0000, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
            32'h0000_0001, 32'h8000_0000, 32'h0000_00ff, 32'h0000_ff00,
            32'h00ff_0000, 32'hff00_0000, 32'h8000_0001, 32'h0100_0080,
            32'h1234_5678, 32'hfedc_ba98, 32'h7fff_ffff, 32'hffff_fffe,
            32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3132_3334, 32'h3030_3030
        };
        foreach (edge_pins[i])
            send_pin(edge_pins[i]);
    endtask

    // Random PINs: a first stretch back to back, then bursts with gaps.
    // Some words are one bit away from the previous one.
    task automatic test_random_pins(input int unsigned count);
        logic [31:0] pin;
        int unsigned i;
        pin = $urandom;
        for (i = 0; i < count; i++)
        begin
            sender_idles = (i >= 100);
            if ($urandom_range(0, 4) == 0)
                pin ^= 32'h1 << $urandom_range(0, 31);
            else
                pin = $urandom;
            send_pin(pin);
        end
        sender_idles = 1'b1;
    endtask

    // Receiver stall pattern: a new random mode at the end of each stretch.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 64);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    // Each digest word taken is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digests.size() == 0)
                report_mismatch($sformatf("unexpected digest %h", m_tdata));
            else
            begin
                if (m_tdata !== pending_digests[0])
                    report_mismatch($sformatf("digest %h, predicted %h",
                                              m_tdata, pending_digests[0]));
                void'(pending_digests.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_pins();
        test_random_pins(RANDOM_PINS);

        // Drain the outstanding digests, then allow the block to settle.
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
